[rtl/fmi_pkg.sv]
// Package: shared types and op codes for the FM-index search block.
package fmi_pkg;
	localparam int MAX_TEXT    = 4096;
	localparam int MAX_SYMBOLS = 16;

	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_BEGIN = 3'd1;
	localparam logic [2:0] OP_EXT   = 3'd2;
	localparam logic [2:0] OP_LF    = 3'd3;
	localparam logic [2:0] OP_CAND  = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  symbol;
		logic        symbol_invalid;
		logic [11:0] position;
	} req_t;

	typedef struct packed {
		logic [12:0] range_start;
		logic [12:0] range_end;
		logic [3:0]  symbol_out;
		logic [12:0] next_position;
		logic [15:0] candidate_mask;
		logic        full_res;
	} rsp_t;
endpackage

[rtl/fmi_if.sv]
// Interfaces: valid/ready channels for request and response items.
interface fmi_req_if;
	logic valid;
	logic ready;
	fmi_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fmi_rsp_if;
	logic valid;
	logic ready;
	fmi_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/fm_index_backward_search.sv]
// Top level: FM-index backward search engine with sequencer over the text memory.
// Each item gives one result, held in an output register until it is taken; the next item
// can be taken in the cycle after the result is taken. Ops that read no text (load, begin,
// undefined, extend after stop, candidates with no letter or after stop, LF out of range)
// go from the idle state through the done state to the output register. Other ops read
// entries through the single read port of the text memory: extend reads entries 0 to
// min(range end, length)-1, candidates read the current range, and LF reads 0 to the
// position and then 0 to position-1 again to rank the fetched symbol. C comes from
// per-symbol offset registers that advance on each accepted load.
module fm_index_backward_search (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata,
	fmi_req_if.sink         req,
	fmi_rsp_if.source       rsp
);
	localparam int AW = $clog2(fmi_pkg::MAX_TEXT);
	localparam int LW = AW + 1;

	// internal op code for the rank pass of an LF step
	localparam logic [2:0] OP_RANK = 3'd7;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [4:0]    alpha_q;
	logic [LW-1:0] len_q, start_q, end_q;
	logic [LW-1:0] off_q [fmi_pkg::MAX_SYMBOLS];
	logic          started_q, stopped_q;
	fmi_pkg::req_t cur_q;
	fmi_pkg::rsp_t out_q;
	logic          out_v_q;
	logic [LW-1:0] idx_q, lim_q;
	logic          rd_v_q;
	logic [LW-1:0] rd_idx_q;
	logic [LW-1:0] rs_q, re_q;
	logic [15:0]   mask_q;
	logic [3:0]    lf_sym_q;

	logic       we;
	logic [3:0] rdata;
	logic [5:0] alpha;

	always_comb begin
		alpha = {1'b0, alpha_q};
		if (alpha < 6'd2) alpha = 6'd2;
		if (alpha > 6'(fmi_pkg::MAX_SYMBOLS)) alpha = 6'(fmi_pkg::MAX_SYMBOLS);
	end

	logic acc;
	assign acc = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	logic load_ok;
	assign load_ok = acc && req.data.op == fmi_pkg::OP_LOAD
		&& len_q < LW'(fmi_pkg::MAX_TEXT) && {2'b0, req.data.symbol} < alpha;
	assign we = load_ok;

	logic [AW-1:0] raddr;
	assign raddr = idx_q[AW-1:0];

	fmi_store #(.DEPTH(fmi_pkg::MAX_TEXT), .AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(len_q[AW-1:0]), .wdata(req.data.symbol),
		.raddr(raddr), .rdata(rdata)
	);

	logic ext_bad;
	assign ext_bad = cur_q.symbol_invalid || {2'b0, cur_q.symbol} >= alpha;

	logic issuing;
	assign issuing = (state_q == ST_SCAN) && idx_q < lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			alpha_q <= 5'd16;
			len_q <= '0;
			start_q <= '0;
			end_q <= '0;
			started_q <= 1'b0;
			stopped_q <= 1'b0;
			out_v_q <= 1'b0;
			rd_v_q <= 1'b0;
			for (int i = 0; i < fmi_pkg::MAX_SYMBOLS; i++) off_q[i] <= '0;
		end else begin
			if (cfg_we) alpha_q <= cfg_wdata;
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			rd_v_q <= issuing;
			rd_idx_q <= idx_q;
			if (issuing) idx_q <= idx_q + 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cur_q <= req.data;
						idx_q <= '0;
						rs_q <= '0;
						re_q <= '0;
						mask_q <= '0;
						lf_sym_q <= '0;
						out_q <= '0;
						lim_q <= '0;
						state_q <= ST_DONE;
						case (req.data.op)
							fmi_pkg::OP_LOAD: begin
								if (len_q >= LW'(fmi_pkg::MAX_TEXT)) out_q.full_res <= 1'b1;
								else if (load_ok) begin
									len_q <= len_q + 1'b1;
									// every symbol above the loaded one starts one entry later
									for (int i = 0; i < fmi_pkg::MAX_SYMBOLS; i++)
										if (i > int'(req.data.symbol))
											off_q[i] <= off_q[i] + 1'b1;
								end
							end
							fmi_pkg::OP_BEGIN: begin
								start_q <= '0;
								end_q <= len_q;
								started_q <= 1'b0;
								stopped_q <= 1'b0;
							end
							fmi_pkg::OP_EXT: begin
								started_q <= 1'b1;
								if (!stopped_q) begin
									lim_q <= ((start_q > end_q) ? start_q : end_q) > len_q
										? len_q : ((start_q > end_q) ? start_q : end_q);
									state_q <= ST_SCAN;
								end
							end
							fmi_pkg::OP_LF: begin
								if ({1'b0, req.data.position} < len_q) begin
									lim_q <= LW'(req.data.position) + 1'b1;
									state_q <= ST_SCAN;
								end
							end
							fmi_pkg::OP_CAND: begin
								if (started_q && !stopped_q) begin
									idx_q <= start_q;
									lim_q <= end_q > len_q ? len_q : end_q;
									state_q <= ST_SCAN;
								end else if (!started_q) begin
									for (int i = 1; i < 16; i++)
										if (6'(i) < alpha) out_q.candidate_mask[i] <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_v_q) begin
						case (cur_q.op)
							fmi_pkg::OP_EXT: if (rdata == cur_q.symbol) begin
								if (rd_idx_q < start_q) rs_q <= rs_q + 1'b1;
								if (rd_idx_q < end_q) re_q <= re_q + 1'b1;
							end
							fmi_pkg::OP_LF: begin
								// last read is the position itself; earlier reads only mark the mask
								if (rd_idx_q == LW'(cur_q.position)) lf_sym_q <= rdata;
								else mask_q[rdata] <= 1'b1;
								if (rd_idx_q != LW'(cur_q.position)) re_q <= re_q;
							end
							default: mask_q[rdata] <= 1'b1;
						endcase
					end
					if (!issuing && !rd_v_q) state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE) begin
				out_v_q <= 1'b1;
				if (cur_q.op == fmi_pkg::OP_EXT && !stopped_q) begin
					if (ext_bad) begin
						start_q <= '0; end_q <= '0; stopped_q <= 1'b1;
						out_q.range_start <= '0; out_q.range_end <= '0;
					end else begin
						start_q <= off_q[cur_q.symbol] + rs_q;
						end_q <= off_q[cur_q.symbol] + re_q;
						out_q.range_start <= 13'(off_q[cur_q.symbol] + rs_q);
						out_q.range_end <= 13'(off_q[cur_q.symbol] + re_q);
						if (rs_q == re_q) stopped_q <= 1'b1;
					end
				end else begin
					out_q.range_start <= 13'(start_q);
					out_q.range_end <= 13'(end_q);
				end
				if (cur_q.op == fmi_pkg::OP_LF && {1'b0, cur_q.position} < len_q) begin
					out_q.symbol_out <= lf_sym_q;
					out_q.next_position <= 13'(off_q[lf_sym_q] + rs_q);
				end
				if (cur_q.op == fmi_pkg::OP_CAND) out_q.candidate_mask <=
					out_q.candidate_mask | mask_q;
			end
			// LF rank: count matches of the fetched symbol below position in a second pass
			if (state_q == ST_SCAN && cur_q.op == fmi_pkg::OP_LF && rd_v_q
				&& rd_idx_q == LW'(cur_q.position)) begin
				idx_q <= '0;
				lim_q <= LW'(cur_q.position);
				cur_q.op <= OP_RANK;
				cur_q.symbol <= rdata;
			end
			if (state_q == ST_SCAN && cur_q.op == OP_RANK && rd_v_q && rdata == cur_q.symbol)
				rs_q <= rs_q + 1'b1;
			if (state_q == ST_SCAN && cur_q.op == OP_RANK && !issuing && !rd_v_q)
				cur_q.op <= fmi_pkg::OP_LF;
		end
	end
endmodule

[rtl/fmi_store.sv]
// Transformed-text memory: one write port, one registered read port.
module fmi_store #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [3:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [3:0]    rdata
);
	logic [3:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/fmi_checker.sv]
// Checker: port-level properties of the search block, bound to the top level.
module fmi_checker (
	input logic clk,
	input logic arst_n,
	input logic in_v, in_r, out_v, out_r,
	input fmi_pkg::rsp_t out_d
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && !out_r |=> out_v && $stable(out_d)) else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_v |-> !in_r) else $error("accepted while result pending");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v |-> out_d.range_start <= out_d.range_end) else $error("bad range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_v && in_r |=> !in_r) else $error("second item taken");
endmodule

bind fm_index_backward_search fmi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_v(req.valid), .in_r(req.ready),
	.out_v(rsp.valid), .out_r(rsp.ready), .out_d(rsp.data)
);
